// ===== hdl/nqsc_pkg.sv =====
`default_nettype none

package nqsc_pkg;

    localparam int FIELD_W   = 31;
    localparam int COUNT_W   = 64;
    localparam int SIZE_W    = 5;
    localparam int IN_DATA_W = 96;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd8;

    typedef logic [FIELD_W-1:0] t_mask;

    // One queued search job, prepared by the front end.
    typedef struct packed {
        t_mask cols;
        t_mask left;
        t_mask right;
        t_mask free;
        t_mask lim;
        logic  start_count;
    } t_item;

    // One saved level of the search stack.
    typedef struct packed {
        t_mask cols;
        t_mask left;
        t_mask right;
        t_mask free;
    } t_level;

endpackage

`default_nettype wire

// ===== hdl/nqsc_front.sv =====
`default_nettype none

module nqsc_front
    import nqsc_pkg::*;
#(
    parameter int MAX_SIZE = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    input  wire logic                 i_tvalid,
    output logic                      o_tready,
    input  wire logic [IN_DATA_W-1:0] i_tdata,
    output logic                      o_item_valid,
    input  wire logic                 i_item_ready,
    output t_item                     o_item
);

    localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;
    logic [31:0]       w_lim_full;
    t_mask             w_lim;
    t_mask             w_cols;
    t_mask             w_left;
    t_mask             w_right;
    t_item             w_item;

    t_item             r_fifo [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    always_comb begin
        w_n        = (r_size > MAX_N) ? MAX_N : r_size;
        w_lim_full = (32'd1 << w_n) - 32'd1;
        w_lim      = w_lim_full[FIELD_W-1:0];
        w_cols     = i_tdata[FIELD_W-1:0];
        w_left     = i_tdata[2*FIELD_W-1:FIELD_W];
        w_right    = i_tdata[3*FIELD_W-1:2*FIELD_W];

        w_item.cols        = w_cols;
        w_item.left        = w_left;
        w_item.right       = w_right;
        w_item.lim         = w_lim;
        // A start row that already fills the board counts once with no search.
        w_item.start_count = (w_cols == w_lim);
        w_item.free        = (w_cols == w_lim) ? '0 : (~(w_cols | w_left | w_right) & w_lim);
    end

    assign o_tready     = (r_count != 2'd2);
    assign w_push       = i_tvalid && o_tready;
    assign o_item_valid = (r_count != 2'd0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("Queue count out of range.");

    a_ptrs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Queue pointers disagree with count.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |=> (r_count != 2'd0 || $past(w_pop)))
        else $error("Queue count jumped.");

endmodule

`default_nettype wire

// ===== hdl/nqsc_back.sv =====
`default_nettype none

module nqsc_back
    import nqsc_pkg::*;
#(
    parameter int MAX_SIZE = 31
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    output logic                    o_item_ready,
    input  wire t_item              i_item,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [COUNT_W-1:0]      o_tdata
);

    localparam int PW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state               r_state;
    logic [PW-1:0]        r_ptr;
    t_mask                r_cols;
    t_mask                r_left;
    t_mask                r_right;
    t_mask                r_free;
    t_mask                r_lim;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;
    t_level               r_stack [MAX_SIZE];

    t_mask                w_bit;
    t_mask                w_nc;
    t_mask                w_nl;
    t_mask                w_nr;
    t_mask                w_nf;
    logic                 w_can_push;
    logic                 w_finish;
    t_level               w_below;

    always_comb begin
        w_bit      = r_free & (~r_free + t_mask'(1));
        w_nc       = r_cols | w_bit;
        w_nl       = (r_left | w_bit) << 1;
        w_nr       = (r_right | w_bit) >> 1;
        w_nf       = ~(w_nc | w_nl | w_nr) & r_lim;
        w_can_push = (({1'b0, r_ptr} + (PW+1)'(1)) < (PW+1)'(MAX_SIZE));
        w_below    = r_stack[r_ptr - PW'(1)];
        w_finish   = (r_state == S_RUN) && (r_free == '0) && (r_ptr == '0)
                     && (!r_out_valid || i_tready);
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_tvalid     = r_out_valid;
    assign o_tdata      = r_out_count;

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && r_free != '0 && w_nc != r_lim && w_can_push) begin
            r_stack[r_ptr] <= '{cols: r_cols, left: r_left, right: r_right,
                                free: r_free ^ w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_cols  <= i_item.cols;
                        r_left  <= i_item.left;
                        r_right <= i_item.right;
                        r_free  <= i_item.free;
                        r_lim   <= i_item.lim;
                        r_count <= COUNT_W'(i_item.start_count);
                        r_ptr   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_free == '0) begin
                        if (r_ptr != '0) begin
                            r_cols  <= w_below.cols;
                            r_left  <= w_below.left;
                            r_right <= w_below.right;
                            r_free  <= w_below.free;
                            r_ptr   <= r_ptr - PW'(1);
                        end else if (w_finish) begin
                            r_out_valid <= 1'b1;
                            r_out_count <= r_count;
                            r_state     <= S_IDLE;
                        end
                    end else if (w_nc == r_lim) begin
                        r_count <= r_count + COUNT_W'(1);
                        r_free  <= r_free ^ w_bit;
                    end else if (w_can_push) begin
                        r_cols  <= w_nc;
                        r_left  <= w_nl;
                        r_right <= w_nr;
                        r_free  <= w_nf;
                        r_ptr   <= r_ptr + PW'(1);
                    end else begin
                        r_free <= r_free ^ w_bit;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ptr} < (PW+1)'(MAX_SIZE)))
        else $error("Stack pointer beyond stack depth.");

    a_idle_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_ptr == '0))
        else $error("Idle with a non-empty stack.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=>
            (r_count == $past(r_count) || r_count == $past(r_count) + COUNT_W'(1)))
        else $error("Running count moved by more than one.");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_free == '0 && r_ptr != '0) |=>
            (r_ptr == $past(r_ptr) - PW'(1)))
        else $error("Pop did not lower the stack pointer.");

endmodule

`default_nettype wire

// ===== hdl/n_queens_solution_counter.sv =====
// N-queens solution counter.
// Each item on the input stream carries the column, left-diagonal and
// right-diagonal masks of a start row; all zeros means the empty board.
// For every item one 64-bit solution count leaves on the output stream,
// in the order the items arrived. The board size is set through the
// configuration channel and applies to items accepted after the write.
// Items pass through a two-entry queue into the search engine, so the
// input keeps accepting while a search runs or a result waits.
// The engine searches depth first, placing one queen at a time and popping
// levels off its stack when a row has no free square left. Throughput is
// set by that single search engine, which takes a new item only when idle.
// Synchronous reset empties the queue, stops any search, drops a pending
// result and sets the board size to eight. When the receiver stalls the
// result is held, the engine waits after its next search and the queue
// fills, after which the input channel deasserts tready.
`default_nettype none

module n_queens_solution_counter
    import nqsc_pkg::*;
#(
    parameter int MAX_SIZE = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,       // board_size
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // start_columns, start_left_diagonals, start_right_diagonals, zero pad
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [COUNT_W-1:0]        o_m_axis_tdata    // solution_count
);

    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;

    nqsc_front #(
        .MAX_SIZE(MAX_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_tvalid     (i_s_axis_tvalid),
        .o_tready     (o_s_axis_tready),
        .i_tdata      (i_s_axis_tdata),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    nqsc_back #(
        .MAX_SIZE(MAX_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import nqsc_pkg::*;

    localparam int STACK_DEPTH = 31;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [COUNT_W-1:0]   o_m_axis_tdata;

    logic [COUNT_W-1:0] expected_counts[$];
    logic [SIZE_W-1:0]  board_n = SIZE_RESET;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_cycles = 0;
    int                 items_sent = 0;
    int                 counts_checked = 0;
    int                 size_writes = 0;
    int                 errors = 0;

    n_queens_solution_counter #(
        .MAX_SIZE(STACK_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Depth-first search over the free squares, one stack level per row.
    function automatic logic [COUNT_W-1:0] count_placements(t_mask cols, t_mask left,
                                                            t_mask right, logic [SIZE_W-1:0] n);
        t_mask              col_lvl[STACK_DEPTH];
        t_mask              left_lvl[STACK_DEPTH];
        t_mask              right_lvl[STACK_DEPTH];
        t_mask              open_lvl[STACK_DEPTH];
        t_mask              lim;
        t_mask              open;
        t_mask              pick;
        t_mask              nc;
        int                 depth;
        logic               done;
        logic [COUNT_W-1:0] total;
        lim = t_mask'((64'd1 << n) - 64'd1);
        if (cols == lim) begin
            return COUNT_W'(1);
        end
        total = '0;
        depth = 0;
        done = 1'b0;
        col_lvl[0] = cols;
        left_lvl[0] = left;
        right_lvl[0] = right;
        open_lvl[0] = ~(cols | left | right) & lim;
        while (!done) begin
            open = open_lvl[depth];
            if (open == '0) begin
                if (depth == 0) begin
                    done = 1'b1;
                end else begin
                    depth--;
                end
            end else begin
                pick = open & (~open + t_mask'(1));
                open_lvl[depth] = open ^ pick;
                nc = col_lvl[depth] | pick;
                if (nc == lim) begin
                    total++;
                end else if (depth + 1 < STACK_DEPTH) begin
                    col_lvl[depth+1] = nc;
                    left_lvl[depth+1] = t_mask'((left_lvl[depth] | pick) << 1);
                    right_lvl[depth+1] = (right_lvl[depth] | pick) >> 1;
                    open_lvl[depth+1] = ~(nc | left_lvl[depth+1] | right_lvl[depth+1]) & lim;
                    depth++;
                end
            end
        end
        return total;
    endfunction

    function automatic t_mask random_diagonals();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return t_mask'($urandom);
            default: return t_mask'($urandom & $urandom & $urandom);
        endcase
    endfunction

    task automatic offer_start_row(input t_mask cols, input t_mask left, input t_mask right);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, right, left, cols};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_counts.push_back(count_placements(cols, left, right, board_n));
        items_sent++;
    endtask

    // Keeps the search small: at most six free columns, but on a board of eight or fewer all may be free.
    task automatic offer_random_row();
        t_mask lim;
        t_mask open;
        t_mask cols;
        int    free_cols;
        int    placed;
        int    pos;
        lim = t_mask'((64'd1 << board_n) - 64'd1);
        if (board_n <= 8 && $urandom_range(0, 5) == 0) begin
            free_cols = board_n;
        end else begin
            free_cols = $urandom_range(0, (board_n < 6) ? board_n : 6);
        end
        open = '0;
        placed = 0;
        while (placed < free_cols) begin
            pos = $urandom_range(0, board_n - 1);
            if (!open[pos]) begin
                open[pos] = 1'b1;
                placed++;
            end
        end
        cols = lim & ~open;
        if ($urandom_range(0, 7) == 0) begin
            cols = cols | (t_mask'($urandom) & ~lim);
        end
        offer_start_row(cols, random_diagonals(), random_diagonals());
    endtask

    task automatic wait_all_counts();
        i_s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_board_size(input logic [SIZE_W-1:0] n);
        wait_all_counts();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board_n = n;
        size_writes++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: solution_count %0d arrived with nothing expected",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                if (o_m_axis_tdata !== expected_counts[0]) begin
                    $display("%0t: solution_count mismatch, expected %0d, actual %0d",
                             $time, expected_counts[0], o_m_axis_tdata);
                    errors++;
                end
                void'(expected_counts.pop_front());
                counts_checked++;
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic test_default_size();
        offer_start_row('0, '0, '0);
        offer_start_row(31'h0000_00FF, '0, '0);
        offer_start_row(31'h4000_0000, '0, '0);
        offer_start_row(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        offer_start_row(31'h0000_0001, 31'h0000_0002, '0);
        offer_start_row('0, 31'h7FFF_FFFF, '0);
    endtask

    task automatic test_tiny_boards();
        write_board_size(5'd0);
        offer_start_row('0, '0, '0);
        offer_start_row(31'h0000_0001, '0, '0);
        offer_start_row(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        write_board_size(5'd1);
        offer_start_row('0, '0, '0);
        offer_start_row(31'h0000_0001, '0, '0);
        offer_start_row('0, 31'h0000_0001, '0);
        write_board_size(5'd2);
        offer_start_row('0, '0, '0);
        write_board_size(5'd3);
        offer_start_row('0, '0, '0);
        write_board_size(5'd4);
        offer_start_row('0, '0, '0);
        write_board_size(5'd6);
        offer_start_row('0, '0, '0);
    endtask

    task automatic test_widest_board();
        write_board_size(5'd31);
        offer_start_row(31'h7FFF_FFFF, '0, '0);
        offer_start_row(31'h7FFF_FFE0, '0, '0);
        offer_start_row(31'h0FFF_FFFF, 31'h0000_0001, 31'h4000_0000);
        offer_start_row(31'h7FFF_FFE0, 31'h7FFF_FFFF, '0);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (4) begin
            write_board_size(SIZE_W'($urandom_range(0, 31)));
            repeat (18) offer_random_row();
        end
    endtask

    task automatic test_random_phases();
        run_random_phase(0, 0);
        run_random_phase(46, 0);
        run_random_phase(0, 46);
        run_random_phase(34, 34);
    endtask

    // The receiver holds off long enough for the queue to fill and tready to drop.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_board_size(5'd6);
        hold_cycles = 400;
        repeat (8) offer_random_row();
        wait_all_counts();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_size();
        test_tiny_boards();
        test_widest_board();
        test_random_phases();
        test_output_stall();
        wait_all_counts();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d start rows over %0d board size writes (sizes 0 to 31),", items_sent,
                 size_writes);
        $display("with sender gaps, receiver stalls and a long hold; %0d counts checked.",
                 counts_checked);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timeout with %0d counts still pending.", expected_counts.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
